// ----- rtl/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Shared sizes and sequencer state codes for the component counter.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MaxVertices = 256;
  localparam int MaxEdges    = 1024;
  localparam int VW = $clog2(MaxVertices);        // vertex index bits
  localparam int EW = $clog2(MaxEdges);           // edge index bits
  localparam int CW = $clog2(MaxEdges + 1);       // edge count bits
  localparam int NW = $clog2(MaxVertices + 1);    // vertex count bits
  localparam int SW = 4;

  localparam logic [SW-1:0] ST_IDLE   = 4'd0;
  localparam logic [SW-1:0] ST_CLEAR  = 4'd1;
  localparam logic [SW-1:0] ST_OUTER  = 4'd2;
  localparam logic [SW-1:0] ST_TOP    = 4'd3;
  localparam logic [SW-1:0] ST_ERD    = 4'd4;
  localparam logic [SW-1:0] ST_ECHK   = 4'd5;
  localparam logic [SW-1:0] ST_POP    = 4'd6;
  localparam logic [SW-1:0] ST_FRD    = 4'd7;
  localparam logic [SW-1:0] ST_FCHK   = 4'd8;
  localparam logic [SW-1:0] ST_DONE   = 4'd9;
  localparam logic [SW-1:0] ST_TOP2   = 4'd10;
  localparam logic [SW-1:0] ST_OCHK   = 4'd11;
  localparam logic [SW-1:0] ST_FVIS   = 4'd12;
  localparam logic [SW-1:0] ST_EVIS   = 4'd13;

endpackage

// ----- rtl/scc_counter.sv -----
// ----------------------------------------------------------------------------
// scc_counter
// Kosaraju component counter with an explicit walk stack and one edge port.
// ----------------------------------------------------------------------------
// An edge item is stored while idle, and the block stays ready for the next item.
// A compute item runs two passes, each a clear of all 256 visited marks followed
// by a walk that reads the edge store once per scanned edge.
// The count leaves through one output register; while it waits, the next item
// is accepted, and a following compute stalls only at its own result.
// Synchronous active-high reset restores vertex_count to 256 and empties the
// edge store and drop flag; memories are not cleared.
module scc_counter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [8:0]                cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [7:0]                src_vertex,
  input  logic [7:0]                dst_vertex,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [8:0]                scc_count,
  output logic                      edges_dropped
);

  localparam int VW = scc_pkg::VW;
  localparam int EW = scc_pkg::EW;
  localparam int CW = scc_pkg::CW;
  localparam int NW = scc_pkg::NW;

  logic [8:0]          vertex_count;
  logic [CW-1:0]       edges_loaded;
  logic                drop_seen;
  logic [scc_pkg::SW-1:0] state;

  logic [VW-1:0] esrc_mem [scc_pkg::MaxEdges];
  logic [VW-1:0] edst_mem [scc_pkg::MaxEdges];
  logic [VW-1:0] fin_mem  [scc_pkg::MaxVertices];
  logic [VW-1:0] stv_mem  [scc_pkg::MaxVertices];
  logic [CW-1:0] stc_mem  [scc_pkg::MaxVertices];
  logic          vis      [scc_pkg::MaxVertices];

  logic          rev;            // second pass walks reversed edges
  logic [NW-1:0] outer;          // first pass: next start; second: finish index
  logic [NW-1:0] depth;
  logic [NW-1:0] fin_len;
  logic [NW-1:0] clr_idx;
  logic [VW-1:0] top;
  logic [CW-1:0] cur;
  logic [VW-1:0] e_src_q, e_dst_q, fin_q, stv_q;
  logic [CW-1:0] stc_q;
  logic [8:0]    count;
  logic [NW-1:0] nv;
  logic [VW-1:0] vis_ra;
  logic          vis_q;

  assign nv = (vertex_count > 9'(scc_pkg::MaxVertices)) ?
              NW'(scc_pkg::MaxVertices) : NW'(vertex_count);

  logic accept;
  logic edge_ok;
  assign in_ready = (state == scc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign edge_ok  = ({1'b0, src_vertex} < nv) && ({1'b0, dst_vertex} < nv) &&
                    (edges_loaded < CW'(scc_pkg::MaxEdges));

  logic          e_from_hit;
  logic [VW-1:0] e_from, e_to;
  assign e_from = rev ? e_dst_q : e_src_q;
  assign e_to   = rev ? e_src_q : e_dst_q;
  assign e_from_hit = (e_from == top) && ({1'b0, e_from} < nv) &&
                      ({1'b0, e_to} < nv) && !vis_q;

  // The visited marks are read in the state before the one that tests them.
  always_comb begin
    unique case (state)
      scc_pkg::ST_FVIS: vis_ra = fin_q;
      scc_pkg::ST_EVIS: vis_ra = e_to;
      default:          vis_ra = outer[VW-1:0];
    endcase
  end

  // Memory ports: one read of each store per cycle, registered.
  always_ff @(posedge clk) begin
    if (accept && !kind && edge_ok && !rst) begin
      esrc_mem[edges_loaded[EW-1:0]] <= src_vertex;
      edst_mem[edges_loaded[EW-1:0]] <= dst_vertex;
    end
    e_src_q <= esrc_mem[cur[EW-1:0]];
    e_dst_q <= edst_mem[cur[EW-1:0]];
    fin_q   <= fin_mem[outer[VW-1:0] - VW'(1)];
    stv_q   <= stv_mem[depth[VW-1:0] - VW'(1)];
    stc_q   <= stc_mem[depth[VW-1:0] - VW'(1)];
    vis_q   <= vis[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= 9'(scc_pkg::MaxVertices);
      edges_loaded  <= '0;
      drop_seen     <= 1'b0;
      state         <= scc_pkg::ST_IDLE;
      out_valid     <= 1'b0;
      rev           <= 1'b0;
      outer         <= '0;
      depth         <= '0;
      fin_len       <= '0;
      clr_idx       <= '0;
      count         <= '0;
    end else begin
      if (cfg_we) vertex_count <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        scc_pkg::ST_IDLE: begin
          if (accept) begin
            if (!kind) begin
              if (!edge_ok) begin
                drop_seen <= 1'b1;
              end else begin
                edges_loaded <= edges_loaded + CW'(1);
              end
            end else begin
              rev     <= 1'b0;
              fin_len <= '0;
              count   <= '0;
              clr_idx <= '0;
              state   <= scc_pkg::ST_CLEAR;
            end
          end
        end
        scc_pkg::ST_CLEAR: begin
          vis[clr_idx[VW-1:0]] <= 1'b0;
          clr_idx <= clr_idx + NW'(1);
          if (clr_idx == NW'(scc_pkg::MaxVertices - 1)) begin
            outer <= rev ? fin_len : '0;
            state <= rev ? scc_pkg::ST_FRD : scc_pkg::ST_OUTER;
          end
        end
        scc_pkg::ST_OUTER: begin
          // Forward pass: try each vertex in ascending order as a start.
          if (outer >= nv) begin
            rev     <= 1'b1;
            clr_idx <= '0;
            state   <= scc_pkg::ST_CLEAR;
          end else begin
            state <= scc_pkg::ST_OCHK;
          end
        end
        scc_pkg::ST_OCHK: begin
          if (!vis_q) begin
            vis[outer[VW-1:0]] <= 1'b1;
            stv_mem[0] <= outer[VW-1:0];
            stc_mem[0] <= '0;
            depth <= NW'(1);
            state <= scc_pkg::ST_TOP;
          end else begin
            state <= scc_pkg::ST_OUTER;
          end
          outer <= outer + NW'(1);
        end
        scc_pkg::ST_FRD: begin
          // Reverse pass: walk finish order from its end.
          if (outer == '0) state <= scc_pkg::ST_DONE;
          else state <= scc_pkg::ST_FVIS;
        end
        scc_pkg::ST_FVIS: state <= scc_pkg::ST_FCHK;
        scc_pkg::ST_FCHK: begin
          outer <= outer - NW'(1);
          if ({1'b0, fin_q} < nv && !vis_q) begin
            count <= count + 9'(1);
            vis[fin_q] <= 1'b1;
            stv_mem[0] <= fin_q;
            stc_mem[0] <= '0;
            depth <= NW'(1);
            state <= scc_pkg::ST_TOP;
          end else begin
            state <= scc_pkg::ST_FRD;
          end
        end
        scc_pkg::ST_TOP: state <= scc_pkg::ST_TOP2;   // stack read in flight
        scc_pkg::ST_TOP2: begin
          top   <= stv_q;
          cur   <= stc_q;
          state <= scc_pkg::ST_ERD;
        end
        scc_pkg::ST_ERD: begin
          if (cur >= edges_loaded) state <= scc_pkg::ST_POP;
          else state <= scc_pkg::ST_EVIS;
        end
        scc_pkg::ST_EVIS: state <= scc_pkg::ST_ECHK;
        scc_pkg::ST_ECHK: begin
          cur <= cur + CW'(1);
          if (e_from_hit) begin
            stc_mem[depth[VW-1:0] - VW'(1)] <= cur + CW'(1);
            vis[e_to] <= 1'b1;
            if (depth < NW'(scc_pkg::MaxVertices)) begin
              stv_mem[depth[VW-1:0]] <= e_to;
              stc_mem[depth[VW-1:0]] <= '0;
              depth <= depth + NW'(1);
            end
            state <= scc_pkg::ST_TOP;
          end else begin
            state <= scc_pkg::ST_ERD;
          end
        end
        scc_pkg::ST_POP: begin
          depth <= depth - NW'(1);
          if (!rev && fin_len < NW'(scc_pkg::MaxVertices)) begin
            fin_mem[fin_len[VW-1:0]] <= top;
            fin_len <= fin_len + NW'(1);
          end
          if (depth == NW'(1)) state <= rev ? scc_pkg::ST_FRD : scc_pkg::ST_OUTER;
          else state <= scc_pkg::ST_TOP;
        end
        scc_pkg::ST_DONE: begin
          if (!out_valid) begin
            scc_count     <= count;
            edges_dropped <= drop_seen;
            out_valid     <= 1'b1;
            edges_loaded  <= '0;
            drop_seen     <= 1'b0;
            state         <= scc_pkg::ST_IDLE;
          end
        end
        default: state <= scc_pkg::ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == scc_pkg::ST_IDLE) else $error("ready outside idle");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= NW'(scc_pkg::MaxVertices)) else $error("stack overflow");
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    edges_loaded <= CW'(scc_pkg::MaxEdges)) else $error("edge count overflow");
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (state == scc_pkg::ST_DONE && !out_valid) |=> (edges_loaded == '0 && out_valid))
    else $error("compute did not clear store");

endmodule
